### src/tblf_pkg.sv
// Package for the temperature band layer finder: widths, codes and the
// log2 / exp2 lookup tables, which are built at elaboration.
// No dependencies.
package tblf_pkg;

	localparam int WEIGHT_FRAC_BITS = 16;
	localparam int LOG_TABLE_DEPTH  = 256;
	localparam int LOG_IDX_W        = $clog2(LOG_TABLE_DEPTH);

	localparam int P_W   = 17;
	localparam int T_W   = 16;
	localparam int W_W   = WEIGHT_FRAC_BITS + 1;
	localparam int LG_W  = 17;
	localparam int LF_W  = 16;
	localparam int L_W   = 21;
	localparam int EX_W  = 32;
	localparam int MA_W  = 24;
	localparam int MB_W  = WEIGHT_FRAC_BITS;
	localparam int MP_W  = MA_W + MB_W;
	localparam int V_W   = 48;
	localparam int N_W   = 5;
	localparam int LX_W  = P_W - 1 - LOG_IDX_W;
	localparam int EF_W  = LF_W - LOG_IDX_W;
	localparam int DC_W  = $clog2(WEIGHT_FRAC_BITS);
	localparam int MC_W  = $clog2(MB_W);

	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_COLD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_WARM = 1'b1;

	localparam logic [CFG_W-1:0] COLD_RST = 16'd25615;
	localparam logic [CFG_W-1:0] WARM_RST = 16'd26115;

	localparam logic [W_W-1:0] W_ONE = {1'b1, {WEIGHT_FRAC_BITS{1'b0}}};
	localparam logic [P_W-1:0] P_MAX = '1;
	localparam logic [N_W-1:0] E_TOP = N_W'(P_W - 1);

	typedef logic [LG_W-1:0] lg_tab_t [0:LOG_TABLE_DEPTH];
	typedef logic [EX_W-1:0] ex_tab_t [0:LOG_TABLE_DEPTH];

	function automatic logic [63:0] isqrt64(logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] b;
		v = v_in;
		r = '0;
		b = 64'd1 << 62;
		for (int k = 0; k < 32; k++) begin
			if (b > v) b = b >> 2;
		end
		for (int k = 0; k < 32; k++) begin
			if (b != 64'd0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
		end
		return r;
	endfunction

	function automatic lg_tab_t build_lg();
		lg_tab_t tab;
		logic [63:0] y;
		logic [19:0] res;
		logic [20:0] rnd;
		for (int i = 0; i <= LOG_TABLE_DEPTH; i++) begin
			y = ((64'(LOG_TABLE_DEPTH) + 64'(i)) << 30) / LOG_TABLE_DEPTH;
			res = '0;
			for (int k = 0; k < 20; k++) begin
				y = (y * y) >> 30;
				res = {res[18:0], 1'b0};
				if (y >= (64'd1 << 31)) begin
					y = y >> 1;
					res[0] = 1'b1;
				end
			end
			rnd = {1'b0, res} + 21'd8;
			tab[i] = rnd[20:4];
		end
		return tab;
	endfunction

	function automatic ex_tab_t build_ex();
		ex_tab_t tab;
		logic [63:0] root [1:20];
		logic [63:0] fb;
		logic [63:0] m;
		root[1] = isqrt64(64'd1 << 61);
		for (int k = 2; k <= 20; k++) root[k] = isqrt64(root[k-1] << 30);
		for (int i = 0; i <= LOG_TABLE_DEPTH; i++) begin
			if (i == LOG_TABLE_DEPTH) begin
				tab[i] = 32'h8000_0000;
			end else begin
				fb = (64'(i) << 20) / LOG_TABLE_DEPTH;
				m = 64'd1 << 30;
				for (int k = 1; k <= 20; k++) begin
					if (fb[20-k]) m = (m * root[k] + (64'd1 << 29)) >> 30;
				end
				tab[i] = m[31:0];
			end
		end
		return tab;
	endfunction

	localparam lg_tab_t LG_TAB = build_lg();
	localparam ex_tab_t EX_TAB = build_ex();

endpackage

### src/tblf_lvl_if.sv
// Level channel: one sounding level per beat, valid/ready handshake.
// Depends on tblf_pkg for field widths.
interface tblf_lvl_if;
	logic                     valid;
	logic                     ready;
	logic [tblf_pkg::P_W-1:0] level_pressure;
	logic [tblf_pkg::T_W-1:0] level_temperature;
	logic                     level_missing;
	logic                     last_level;

	modport source (output valid, level_pressure, level_temperature, level_missing,
		last_level, input ready);
	modport sink (input valid, level_pressure, level_temperature, level_missing,
		last_level, output ready);
endinterface

### src/tblf_res_if.sv
// Result channel: one layer result per beat, valid/ready handshake.
// Depends on tblf_pkg for field widths.
interface tblf_res_if;
	logic                     valid;
	logic                     ready;
	logic                     layer_found;
	logic [tblf_pkg::P_W-1:0] bottom_pressure;
	logic [tblf_pkg::P_W-1:0] top_pressure;

	modport source (output valid, layer_found, bottom_pressure, top_pressure, input ready);
	modport sink (input valid, layer_found, bottom_pressure, top_pressure, output ready);
endinterface

### src/temperature_band_layer_finder.sv
// Temperature band layer finder, top level: sequencer, state and result register.
// Depends on tblf_pkg, tblf_lvl_if, tblf_res_if, tblf_div and tblf_mul.
//
// Usage: send the levels of one profile on lvl, top level first, the surface
// level flagged last_level. Missing levels are skipped. The beat flagged last
// produces exactly one beat on res: layer_found and the bottom and top
// pressures of the band layer (zero when none found). Other beats produce none.
// Band limits are to be written through cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
// One level is taken at a time; lvl.ready is high only between levels.
// A missing or first level, or one after the scan stops, needs no arithmetic;
// a segment may take a weight division for each band limit, and each pressure
// interpolated takes two log normalisations, four passes of the serial
// multiplier and an exp shift. The divider and multiplier work one bit a cycle.
// The result sits in an output register; a stalled receiver holds the next
// last beat only, earlier levels still go through.
// Reset restores the default limits and clears all scan state.
module temperature_band_layer_finder (
	input  logic                             clk,
	input  logic                             arst_n,
	tblf_lvl_if.sink                         lvl,
	tblf_res_if.source                       res,
	input  logic                             cfg_we,
	input  logic [tblf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tblf_pkg::CFG_W-1:0]       cfg_data
);
	import tblf_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_CHK, S_WPREP, S_WDIV, S_DECIDE, S_IPREP, S_LNORM, S_LMUL,
		S_DMUL, S_EPREP, S_EMUL, S_ESHIFT, S_IEND, S_FIN, S_EMIT
	} state_t;

	state_t          state_q;
	logic [T_W-1:0]  cold_q, warm_q;
	logic [P_W-1:0]  in_p_q;
	logic [T_W-1:0]  in_t_q;
	logic            in_miss_q, in_last_q, upd_q;
	logic [P_W-1:0]  pp_q, top_q, bot_q;
	logic [T_W-1:0]  pt_q;
	logic            have_prev_q, found_top_q, scan_done_q;
	logic            neg_q, wsel_q, itgt_q, lsel_q;
	logic [T_W-1:0]  adt_q;
	logic [W_W-1:0]  wc_q, ww_q, iw_q;
	logic [P_W-1:0]  xn_q;
	logic [N_W-1:0]  e_q, n_q;
	logic [L_W-1:0]  l1_q, l2_q;
	logic [LF_W-1:0] ef_q;
	logic [V_W-1:0]  v_q;
	logic            div_start_q, mul_start_q;
	logic [T_W-1:0]  div_n_q;
	logic [MA_W-1:0] mul_a_q;
	logic [MB_W-1:0] mul_b_q;
	logic            res_valid_q, res_found_q;
	logic [P_W-1:0]  res_bot_q, res_top_q;

	logic                        div_done, mul_done;
	logic [WEIGHT_FRAC_BITS-1:0] div_q;
	logic [MP_W-1:0]             mul_p;

	logic [W_W-1:0]        w_in, w_out, w_quick;
	logic                  w_is_quick;
	logic [T_W-1:0]        a_lim;
	logic signed [T_W:0]   a_raw, a_abs, dt_raw;
	logic [LOG_IDX_W-1:0]  lg_idx, ex_idx;
	logic [LG_W-1:0]       lg_lo, lg_hi, lg_diff;
	logic [L_W-1:0]        log_val, d_val, t_val, l_new;
	logic [MP_W-1:0]       t_full;
	logic [EX_W-1:0]       ex_lo, ex_hi, ex_diff, m_val;
	logic [V_W-1:0]        p_sum;
	logic [P_W:0]          p_raw;
	logic [P_W-1:0]        p_cl, p_lo, p_hi, p_fin, ip_val;
	logic                  ip_done;

	tblf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (div_n_q),
		.divisor  (adt_q),
		.done     (div_done),
		.quotient (div_q)
	);

	tblf_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start_q),
		.mcand   (mul_a_q),
		.mplier  (mul_b_q),
		.done    (mul_done),
		.product (mul_p)
	);

	always_comb begin
		w_in  = (wc_q < ww_q) ? wc_q : ww_q;
		w_out = (wc_q < ww_q) ? ww_q : wc_q;

		a_lim  = wsel_q ? warm_q : cold_q;
		a_raw  = $signed({1'b0, a_lim}) - $signed({1'b0, pt_q});
		a_abs  = neg_q ? -a_raw : a_raw;
		dt_raw = $signed({1'b0, in_t_q}) - $signed({1'b0, pt_q});
		w_is_quick = a_abs[T_W] || (a_abs == '0) || (a_abs[T_W-1:0] >= adt_q);
		w_quick    = (a_abs[T_W] || (a_abs == '0)) ? '0 : W_ONE;

		lg_idx  = xn_q[P_W-2 -: LOG_IDX_W];
		lg_lo   = LG_TAB[{1'b0, lg_idx}];
		lg_hi   = LG_TAB[{1'b0, lg_idx} + (LOG_IDX_W+1)'(1)];
		lg_diff = lg_hi - lg_lo;
		log_val = {e_q, {LF_W{1'b0}}} + L_W'(lg_lo) + mul_p[LX_W +: L_W];
		d_val   = (log_val >= l1_q) ? log_val - l1_q : l1_q - log_val;

		t_full = mul_p + MP_W'({1'b1, {(WEIGHT_FRAC_BITS-1){1'b0}}});
		t_val  = t_full[WEIGHT_FRAC_BITS +: L_W];
		l_new  = (l2_q >= l1_q) ? l1_q + t_val : l1_q - t_val;

		ex_idx  = ef_q[LF_W-1 -: LOG_IDX_W];
		ex_lo   = EX_TAB[{1'b0, ex_idx}];
		ex_hi   = EX_TAB[{1'b0, ex_idx} + (LOG_IDX_W+1)'(1)];
		ex_diff = ex_hi - ex_lo;
		m_val   = ex_lo + mul_p[EF_W +: EX_W];

		p_sum = v_q + V_W'({1'b1, 29'b0});
		p_raw = p_sum[V_W-1:30] > 18'({1'b0, P_MAX}) ? {1'b0, P_MAX} : p_sum[30 +: P_W+1];
		p_cl  = p_raw[P_W-1:0];
		p_lo  = (pp_q < in_p_q) ? pp_q : in_p_q;
		p_hi  = (pp_q < in_p_q) ? in_p_q : pp_q;
		if (p_cl < p_lo) p_fin = p_lo;
		else if (p_cl > p_hi) p_fin = p_hi;
		else p_fin = p_cl;

		ip_done = ((state_q == S_IPREP) && ((iw_q == '0) || (iw_q >= W_ONE)))
			|| (state_q == S_IEND);
		if (state_q == S_IPREP) ip_val = (iw_q == '0) ? pp_q : in_p_q;
		else ip_val = p_fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cold_q      <= COLD_RST;
			warm_q      <= WARM_RST;
			in_p_q      <= '0;
			in_t_q      <= '0;
			in_miss_q   <= 1'b0;
			in_last_q   <= 1'b0;
			upd_q       <= 1'b0;
			pp_q        <= '0;
			pt_q        <= '0;
			top_q       <= '0;
			bot_q       <= '0;
			have_prev_q <= 1'b0;
			found_top_q <= 1'b0;
			scan_done_q <= 1'b0;
			neg_q       <= 1'b0;
			wsel_q      <= 1'b0;
			itgt_q      <= 1'b0;
			lsel_q      <= 1'b0;
			adt_q       <= '0;
			wc_q        <= '0;
			ww_q        <= '0;
			iw_q        <= '0;
			xn_q        <= '0;
			e_q         <= '0;
			n_q         <= '0;
			l1_q        <= '0;
			l2_q        <= '0;
			ef_q        <= '0;
			v_q         <= '0;
			div_start_q <= 1'b0;
			mul_start_q <= 1'b0;
			div_n_q     <= '0;
			mul_a_q     <= '0;
			mul_b_q     <= '0;
			res_valid_q <= 1'b0;
			res_found_q <= 1'b0;
			res_bot_q   <= '0;
			res_top_q   <= '0;
		end else begin
			div_start_q <= 1'b0;
			mul_start_q <= 1'b0;

			if (cfg_we) begin
				unique case (cfg_index)
					REG_COLD: cold_q <= cfg_data;
					REG_WARM: warm_q <= cfg_data;
				endcase
			end

			if (res_valid_q && res.ready) res_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (lvl.valid) begin
						in_p_q    <= lvl.level_pressure;
						in_t_q    <= lvl.level_temperature;
						in_miss_q <= lvl.level_missing;
						in_last_q <= lvl.last_level;
						state_q   <= S_CHK;
					end
				end
				S_CHK: begin
					upd_q <= !in_miss_q && !scan_done_q;
					if (in_miss_q || scan_done_q) begin
						state_q <= S_FIN;
					end else if (!have_prev_q) begin
						have_prev_q <= 1'b1;
						state_q     <= S_FIN;
					end else if (dt_raw == '0) begin
						if (pt_q >= cold_q && pt_q <= warm_q) begin
							wc_q <= '0;
							ww_q <= W_ONE;
						end else begin
							wc_q <= W_ONE;
							ww_q <= '0;
						end
						state_q <= S_DECIDE;
					end else begin
						neg_q   <= dt_raw[T_W];
						adt_q   <= dt_raw[T_W] ? T_W'(-dt_raw) : dt_raw[T_W-1:0];
						wsel_q  <= 1'b0;
						state_q <= S_WPREP;
					end
				end
				S_WPREP: begin
					if (w_is_quick) begin
						if (!wsel_q) begin
							wc_q   <= w_quick;
							wsel_q <= 1'b1;
						end else begin
							ww_q    <= w_quick;
							state_q <= S_DECIDE;
						end
					end else begin
						div_n_q     <= a_abs[T_W-1:0];
						div_start_q <= 1'b1;
						state_q     <= S_WDIV;
					end
				end
				S_WDIV: begin
					if (div_done) begin
						if (!wsel_q) begin
							wc_q    <= {1'b0, div_q};
							wsel_q  <= 1'b1;
							state_q <= S_WPREP;
						end else begin
							ww_q    <= {1'b0, div_q};
							state_q <= S_DECIDE;
						end
					end
				end
				S_DECIDE: begin
					if (w_in < w_out) begin
						iw_q    <= found_top_q ? w_out : w_in;
						itgt_q  <= found_top_q;
						state_q <= S_IPREP;
					end else begin
						if (found_top_q) scan_done_q <= 1'b1;
						state_q <= S_FIN;
					end
				end
				S_IPREP: begin
					if (!ip_done) begin
						xn_q    <= (pp_q == '0) ? P_W'(1) : pp_q;
						e_q     <= E_TOP;
						lsel_q  <= 1'b0;
						state_q <= S_LNORM;
					end
				end
				S_LNORM: begin
					if (xn_q[P_W-1]) begin
						mul_a_q     <= MA_W'(lg_diff);
						mul_b_q     <= MB_W'(xn_q[LX_W-1:0]);
						mul_start_q <= 1'b1;
						state_q     <= S_LMUL;
					end else begin
						xn_q <= {xn_q[P_W-2:0], 1'b0};
						e_q  <= e_q - 1'b1;
					end
				end
				S_LMUL: begin
					if (mul_done) begin
						if (!lsel_q) begin
							l1_q    <= log_val;
							lsel_q  <= 1'b1;
							xn_q    <= (in_p_q == '0) ? P_W'(1) : in_p_q;
							e_q     <= E_TOP;
							state_q <= S_LNORM;
						end else begin
							l2_q        <= log_val;
							mul_a_q     <= MA_W'(d_val);
							mul_b_q     <= iw_q[WEIGHT_FRAC_BITS-1:0];
							mul_start_q <= 1'b1;
							state_q     <= S_DMUL;
						end
					end
				end
				S_DMUL: begin
					if (mul_done) begin
						ef_q    <= l_new[LF_W-1:0];
						n_q     <= l_new[L_W-1:LF_W];
						state_q <= S_EPREP;
					end
				end
				S_EPREP: begin
					mul_a_q     <= ex_diff[MA_W-1:0];
					mul_b_q     <= MB_W'(ef_q[EF_W-1:0]);
					mul_start_q <= 1'b1;
					state_q     <= S_EMUL;
				end
				S_EMUL: begin
					if (mul_done) begin
						v_q     <= V_W'(m_val);
						state_q <= S_ESHIFT;
					end
				end
				S_ESHIFT: begin
					if (n_q == '0) begin
						state_q <= S_IEND;
					end else begin
						v_q <= {v_q[V_W-2:0], 1'b0};
						n_q <= n_q - 1'b1;
					end
				end
				S_IEND: begin
					state_q <= S_IEND;
				end
				S_FIN: begin
					if (upd_q) begin
						pp_q <= in_p_q;
						pt_q <= in_t_q;
					end
					state_q <= in_last_q ? S_EMIT : S_IDLE;
				end
				S_EMIT: begin
					if (!res_valid_q || res.ready) begin
						res_valid_q <= 1'b1;
						res_found_q <= found_top_q;
						res_bot_q   <= found_top_q ? bot_q : '0;
						res_top_q   <= found_top_q ? top_q : '0;
						pp_q        <= '0;
						pt_q        <= '0;
						top_q       <= '0;
						bot_q       <= '0;
						have_prev_q <= 1'b0;
						found_top_q <= 1'b0;
						scan_done_q <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			// commit an interpolated pressure: top first, then bottom
			if (ip_done) begin
				if (!itgt_q) begin
					top_q       <= ip_val;
					found_top_q <= 1'b1;
					iw_q        <= w_out;
					itgt_q      <= 1'b1;
					state_q     <= S_IPREP;
				end else begin
					bot_q <= ip_val;
					if (w_out < W_ONE) scan_done_q <= 1'b1;
					state_q <= S_FIN;
				end
			end
		end
	end

	assign lvl.ready           = (state_q == S_IDLE);
	assign res.valid           = res_valid_q;
	assign res.layer_found     = res_found_q;
	assign res.bottom_pressure = res_bot_q;
	assign res.top_pressure    = res_top_q;

`ifndef SYNTH
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_WDIV)
		else $error("divider result with no division pending");

	a_mul_owner: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == S_LMUL || state_q == S_DMUL || state_q == S_EMUL))
		else $error("multiplier result with no product pending");

	a_stop_after_top: assert property (@(posedge clk) disable iff (!arst_n)
		scan_done_q |-> found_top_q)
		else $error("scan stopped before any top was found");
`endif
endmodule

### src/tblf_div.sv
// Bit-serial restoring divider for the band weights, one quotient bit a cycle.
// Depends on tblf_pkg.
module tblf_div (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic [tblf_pkg::T_W-1:0]               dividend,
	input  logic [tblf_pkg::T_W-1:0]               divisor,
	output logic                                   done,
	output logic [tblf_pkg::WEIGHT_FRAC_BITS-1:0]  quotient
);
	import tblf_pkg::*;

	logic [T_W-1:0]              rem_q;
	logic [WEIGHT_FRAC_BITS-1:0] quo_q;
	logic [DC_W-1:0]             cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [T_W:0]                shifted;
	logic [T_W:0]                diff;
	logic                        fits;

	assign shifted = {rem_q, 1'b0};
	assign fits    = shifted >= {1'b0, divisor};
	assign diff    = shifted - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			quo_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= dividend;
				quo_q  <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= fits ? diff[T_W-1:0] : shifted[T_W-1:0];
				quo_q <= {quo_q[WEIGHT_FRAC_BITS-2:0], fits};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DC_W'(WEIGHT_FRAC_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

### src/tblf_mul.sv
// Shift-add multiplier, one multiplier bit a cycle, shared by the log,
// interpolation and exp steps. Depends on tblf_pkg.
module tblf_mul (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [tblf_pkg::MA_W-1:0]  mcand,
	input  logic [tblf_pkg::MB_W-1:0]  mplier,
	output logic                       done,
	output logic [tblf_pkg::MP_W-1:0]  product
);
	import tblf_pkg::*;

	logic [MP_W-1:0] acc_q;
	logic [MP_W-1:0] a_q;
	logic [MB_W-1:0] b_q;
	logic [MC_W-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			a_q    <= '0;
			b_q    <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				acc_q  <= '0;
				a_q    <= MP_W'(mcand);
				b_q    <= mplier;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (b_q[0]) acc_q <= acc_q + a_q;
				a_q   <= {a_q[MP_W-2:0], 1'b0};
				b_q   <= {1'b0, b_q[MB_W-1:1]};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == MC_W'(MB_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done    = done_q;
	assign product = acc_q;
endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// Testbench for temperature_band_layer_finder: directed and random sounding profiles,
// results checked against an in-bench log-pressure band predictor or, for some directed rows, written expectations.
// Depends on tblf_pkg, tblf_lvl_if, tblf_res_if and the block itself.
module tb;
	import tblf_pkg::*;

	typedef struct packed {
		logic [P_W-1:0] p;
		logic [T_W-1:0] t;
		logic           miss;
		logic           last;
	} level_t;

	typedef struct packed {
		logic           found;
		logic [P_W-1:0] bot;
		logic [P_W-1:0] top;
	} layer_t;

	typedef struct packed {
		level_t lv;
		logic   typed;
		layer_t want;
	} row_t;

	localparam int WONE = 1 << WEIGHT_FRAC_BITS;
	localparam int NDIR = 21;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_COLD;
	logic [CFG_W-1:0] cfg_data = '0;

	tblf_lvl_if lvl_ch ();
	tblf_res_if res_ch ();

	temperature_band_layer_finder dut (
		.clk(clk), .arst_n(arst_n), .lvl(lvl_ch), .res(res_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	longint unsigned log_lut [0:LOG_TABLE_DEPTH];
	longint unsigned exp_lut [0:LOG_TABLE_DEPTH];
	int unsigned cold_lim, warm_lim;
	int unsigned last_p, last_t, top_p, bot_p;
	bit have_last, top_seen, band_left;

	layer_t layer_q [$];
	int mismatches = 0;
	bit failed = 1'b0;
	int send_idle = 32, recv_idle = 70;
	int quiet = 0;
	int levels_sent = 0;

	function automatic longint unsigned int_sqrt(longint unsigned v_in);
		longint unsigned v, r, b;
		v = v_in;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else r = r >> 1;
			b = b >> 2;
		end
		return r;
	endfunction

	task automatic fill_luts();
		longint unsigned rt [1:20];
		longint unsigned y, fb, m;
		int unsigned acc;
		rt[1] = int_sqrt(64'd1 << 61);
		for (int k = 2; k <= 20; k++) rt[k] = int_sqrt(rt[k-1] << 30);
		for (int i = 0; i <= LOG_TABLE_DEPTH; i++) begin
			y = ((64'(LOG_TABLE_DEPTH) + 64'(i)) << 30) / LOG_TABLE_DEPTH;
			acc = 0;
			for (int k = 0; k < 20; k++) begin
				y = (y * y) >> 30;
				acc = acc << 1;
				if (y >= (64'd1 << 31)) begin
					y = y >> 1;
					acc = acc | 1;
				end
			end
			log_lut[i] = 64'((acc + 8) >> 4);
			if (i == LOG_TABLE_DEPTH) exp_lut[i] = 64'd1 << 31;
			else begin
				fb = (64'(i) << 20) / LOG_TABLE_DEPTH;
				m = 64'd1 << 30;
				for (int k = 1; k <= 20; k++)
					if (fb[20-k]) m = (m * rt[k] + (64'd1 << 29)) >> 30;
				exp_lut[i] = m;
			end
		end
	endtask

	function automatic longint unsigned log_pa(int unsigned x_in);
		int unsigned x, e;
		longint unsigned fr, pr, ix, r;
		x = (x_in == 0) ? 1 : x_in;
		e = 0;
		while (e < 16 && (x >> (e + 1)) != 0) e++;
		fr = (64'(x) << (31 - e)) & 64'h7FFF_FFFF;
		pr = fr * LOG_TABLE_DEPTH;
		ix = pr >> 31;
		r = pr & 64'h7FFF_FFFF;
		return (64'(e) << 16) + log_lut[ix] + (((log_lut[ix+1] - log_lut[ix]) * r) >> 31);
	endfunction

	function automatic int unsigned pa_of_log(longint unsigned l);
		longint unsigned n, pr, ix, r, m, p;
		n = l >> 16;
		pr = (l & 64'hFFFF) * LOG_TABLE_DEPTH;
		ix = pr >> 16;
		r = pr & 64'hFFFF;
		m = exp_lut[ix] + (((exp_lut[ix+1] - exp_lut[ix]) * r) >> 16);
		if (n > 17) n = 17;
		p = ((m << n) + (64'd1 << 29)) >> 30;
		return (p > 64'h1FFFF) ? 32'h1FFFF : 32'(p);
	endfunction

	function automatic int unsigned clip_pa(int unsigned p1, int unsigned p2, int unsigned w);
		longint unsigned l1, l2, d, t, l;
		int unsigned p, lo, hi;
		if (w == 0) return p1;
		if (w >= WONE) return p2;
		l1 = log_pa(p1);
		l2 = log_pa(p2);
		d = (l2 >= l1) ? l2 - l1 : l1 - l2;
		t = (d * w + (64'd1 << (WEIGHT_FRAC_BITS - 1))) >> WEIGHT_FRAC_BITS;
		l = (l2 >= l1) ? l1 + t : l1 - t;
		p = pa_of_log(l);
		lo = (p1 < p2) ? p1 : p2;
		hi = (p1 < p2) ? p2 : p1;
		if (p < lo) p = lo;
		if (p > hi) p = hi;
		return p;
	endfunction

	function automatic int unsigned edge_frac(int a_in, int dt_in);
		int a, dt;
		a = a_in;
		dt = dt_in;
		if (dt < 0) begin
			a = -a;
			dt = -dt;
		end
		if (a <= 0) return 0;
		if (a >= dt) return WONE;
		return 32'((64'(a) << WEIGHT_FRAC_BITS) / 64'(dt));
	endfunction

	task automatic clear_scan();
		last_p = 0; last_t = 0; top_p = 0; bot_p = 0;
		have_last = 0; top_seen = 0; band_left = 0;
	endtask

	task automatic scan_level(input level_t lv, output bit emits, output layer_t r);
		int dt;
		int unsigned wc, ww, w_in, w_out;
		emits = 0;
		r = '0;
		if (!lv.miss && !band_left) begin
			if (!have_last) have_last = 1;
			else begin
				dt = int'(lv.t) - int'(last_t);
				if (dt != 0) begin
					wc = edge_frac(int'(cold_lim) - int'(last_t), dt);
					ww = edge_frac(int'(warm_lim) - int'(last_t), dt);
					w_in = (wc < ww) ? wc : ww;
					w_out = (wc < ww) ? ww : wc;
				end else if (last_t >= cold_lim && last_t <= warm_lim) begin
					w_in = 0; w_out = WONE;
				end else begin
					w_in = WONE; w_out = 0;
				end
				if (w_in < w_out) begin
					if (!top_seen) begin
						top_p = clip_pa(last_p, 32'(lv.p), w_in);
						top_seen = 1;
					end
					bot_p = clip_pa(last_p, 32'(lv.p), w_out);
					if (w_out < WONE) band_left = 1;
				end else if (top_seen) band_left = 1;
			end
			last_p = 32'(lv.p);
			last_t = 32'(lv.t);
		end
		if (lv.last) begin
			emits = 1;
			r.found = top_seen;
			r.bot = top_seen ? P_W'(bot_p) : '0;
			r.top = top_seen ? P_W'(top_p) : '0;
			clear_scan();
		end
	endtask

	task automatic put_level(input level_t lv, input bit typed, input layer_t want);
		bit emits;
		layer_t r;
		while ($urandom_range(99) < send_idle) begin
			lvl_ch.valid <= 1'b0;
			@(posedge clk);
		end
		lvl_ch.valid <= 1'b1;
		lvl_ch.level_pressure <= lv.p;
		lvl_ch.level_temperature <= lv.t;
		lvl_ch.level_missing <= lv.miss;
		lvl_ch.last_level <= lv.last;
		@(posedge clk);
		while (!lvl_ch.ready) @(posedge clk);
		scan_level(lv, emits, r);
		if (emits) layer_q.push_back(typed ? want : r);
		levels_sent++;
		if (levels_sent == 520) begin
			send_idle = 70; recv_idle = 32;
		end else if (levels_sent == 1040) begin
			send_idle = 0; recv_idle = 0;
		end
	endtask

	task automatic drain();
		lvl_ch.valid <= 1'b0;
		@(posedge clk);
		while (layer_q.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic set_band(input int unsigned cold, input int unsigned warm);
		cfg_we <= 1'b1; cfg_index <= REG_COLD; cfg_data <= CFG_W'(cold);
		@(posedge clk);
		cfg_index <= REG_WARM; cfg_data <= CFG_W'(warm);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		cold_lim = cold;
		warm_lim = warm;
	endtask

	task automatic random_profile();
		level_t lv;
		int n, lo, hi;
		int unsigned p;
		n = $urandom_range(12, 1);
		lo = ((cold_lim < warm_lim) ? int'(cold_lim) : int'(warm_lim)) - 1500;
		hi = ((cold_lim < warm_lim) ? int'(warm_lim) : int'(cold_lim)) + 1500;
		if (lo < 0) lo = 0;
		if (hi > 40000) hi = 40000;
		p = $urandom_range(30000, 0);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) == 0) begin
				lv.p = P_W'($urandom_range(110000, 0));
				lv.t = T_W'($urandom_range(40000, 0));
			end else begin
				lv.p = P_W'(p);
				lv.t = T_W'($urandom_range(hi, lo));
			end
			lv.miss = ($urandom_range(9) == 0);
			lv.last = (i == n - 1);
			put_level(lv, 1'b0, '0);
			p = p + $urandom_range(15000, 0);
			if (p > 110000) p = $urandom_range(110000, 100000);
		end
	endtask

	row_t dir_rows [NDIR] = '{
		'{'{17'd50000, 16'd26000, 1'b0, 1'b1}, 1'b1, '{1'b0, 17'd0, 17'd0}},
		'{'{17'd30000, 16'd25000, 1'b0, 1'b0}, 1'b0, '0},
		'{'{17'd50000, 16'd25865, 1'b0, 1'b0}, 1'b0, '0},
		'{'{17'd70000, 16'd27000, 1'b0, 1'b1}, 1'b0, '0},
		'{'{17'd40000, 16'd25800, 1'b0, 1'b0}, 1'b0, '0},
		'{'{17'd60000, 16'd25800, 1'b0, 1'b1}, 1'b1, '{1'b1, 17'd60000, 17'd40000}},
		'{'{17'd0, 16'd25700, 1'b0, 1'b0}, 1'b0, '0},
		'{'{17'd100, 16'd25700, 1'b1, 1'b1}, 1'b1, '{1'b0, 17'd0, 17'd0}},
		'{'{17'd0, 16'd25700, 1'b0, 1'b0}, 1'b0, '0},
		'{'{17'd100, 16'd25700, 1'b0, 1'b1}, 1'b1, '{1'b1, 17'd100, 17'd0}},
		'{'{17'd0, 16'd25000, 1'b0, 1'b0}, 1'b0, '0},
		'{'{17'd1000, 16'd27000, 1'b0, 1'b1}, 1'b0, '0},
		'{'{17'd20000, 16'd25000, 1'b0, 1'b0}, 1'b0, '0},
		'{'{17'd30000, 16'd25865, 1'b0, 1'b0}, 1'b0, '0},
		'{'{17'd45000, 16'd27000, 1'b0, 1'b0}, 1'b0, '0},
		'{'{17'd60000, 16'd25865, 1'b0, 1'b0}, 1'b0, '0},
		'{'{17'd80000, 16'd25900, 1'b0, 1'b1}, 1'b0, '0},
		'{'{17'd110000, 16'd40000, 1'b0, 1'b0}, 1'b0, '0},
		'{'{17'd110000, 16'd0, 1'b0, 1'b1}, 1'b0, '0},
		'{'{17'd110000, 16'd0, 1'b0, 1'b0}, 1'b0, '0},
		'{'{17'd131071, 16'd65535, 1'b1, 1'b1}, 1'b1, '{1'b0, 17'd0, 17'd0}}
	};

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				if (layer_q.size() == 0) begin
					failed <= 1'b1;
					if (mismatches < 10)
						$display("unexpected result beat %0d %0d %0d", res_ch.layer_found,
							res_ch.bottom_pressure, res_ch.top_pressure);
					mismatches <= mismatches + 1;
				end else begin
					if (res_ch.layer_found !== layer_q[0].found ||
					    res_ch.bottom_pressure !== layer_q[0].bot ||
					    res_ch.top_pressure !== layer_q[0].top) begin
						failed <= 1'b1;
						if (mismatches < 10)
							$display("mismatch: want %0d %0d %0d got %0d %0d %0d",
								layer_q[0].found, layer_q[0].bot, layer_q[0].top,
								res_ch.layer_found, res_ch.bottom_pressure,
								res_ch.top_pressure);
						mismatches <= mismatches + 1;
					end
					void'(layer_q.pop_front());
				end
			end
			if ((res_ch.valid && res_ch.ready) || (lvl_ch.valid && lvl_ch.ready)) quiet <= 0;
			else if (quiet >= 20000) begin
				$display("RESULT: ERROR");
				$finish;
			end else quiet <= quiet + 1;
		end
		res_ch.ready <= ($urandom_range(99) >= recv_idle);
	end

	initial begin
		lvl_ch.valid = 1'b0;
		lvl_ch.level_pressure = '0;
		lvl_ch.level_temperature = '0;
		lvl_ch.level_missing = 1'b0;
		lvl_ch.last_level = 1'b0;
		fill_luts();
		cold_lim = 32'(COLD_RST);
		warm_lim = 32'(WARM_RST);
		clear_scan();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < NDIR; i++)
			put_level(dir_rows[i].lv, dir_rows[i].typed, dir_rows[i].want);
		for (int ph = 0; ph < 6; ph++) begin
			drain();
			case (ph)
				0: set_band(32'(COLD_RST), 32'(WARM_RST));
				1: set_band(0, 40000);
				2: set_band(40000, 0);
				3: set_band(26000, 25000);
				4: set_band(40000, 40000);
				default: set_band($urandom_range(30000, 20000), $urandom_range(30000, 20000));
			endcase
			while (levels_sent < NDIR + (ph + 1) * 255) random_profile();
		end
		drain();
		if (!failed) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end
endmodule
